// ===== rtl/hilbert_curve_converter_top_macros.svh =====
// Assertion helpers for the converter checks.
// Each use expands to one labeled concurrent assertion on the rising edge of clk.
`ifndef HILBERT_CURVE_CONVERTER_TOP_MACROS_SVH
`define HILBERT_CURVE_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, masked while rst is high.
`define HCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while rst is high.
`define HCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that stays active through reset.
`define HCC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hcc_pkg.sv =====
package hcc_pkg;

  localparam int HCC_MAX_ORDER = 16;
  localparam int HCC_HALF      = HCC_MAX_ORDER / 2;
  localparam int HCC_ORDER_W   = 5;
  localparam int HCC_COORD_W   = 16;
  localparam int HCC_INDEX_W   = 32;
  localparam int HCC_DATA_W    = HCC_INDEX_W + 2 * HCC_COORD_W;
  localparam int HCC_APB_AW    = 3;

  localparam logic [HCC_ORDER_W-1:0] HCC_ORDER_RESET = 5'd13;

  // Register index codes (paddr[2]).
  localparam logic HCC_REG_ORDER = 1'b0;

  // Conversion direction codes.
  localparam logic HCC_KIND_TO_POINT = 1'b0;
  localparam logic HCC_KIND_TO_INDEX = 1'b1;

  // Partial conversion carried between pipeline stages.
  // To point: px/py partial point, acc holds the curve index.
  // To index: px/py turned point, acc holds the partial distance.
  typedef struct packed {
    logic                   kind;
    logic [HCC_COORD_W-1:0] px;
    logic [HCC_COORD_W-1:0] py;
    logic [HCC_INDEX_W-1:0] acc;
  } stage_t;

  function automatic logic [HCC_ORDER_W-1:0] eff_order(input logic [HCC_ORDER_W-1:0] o);
    return (o > HCC_ORDER_W'(HCC_MAX_ORDER)) ? HCC_ORDER_W'(HCC_MAX_ORDER) : o;
  endfunction

  function automatic logic [HCC_COORD_W-1:0] coord_mask(input logic [HCC_ORDER_W-1:0] ord);
    logic [HCC_COORD_W:0] m;
    m = ((HCC_COORD_W+1)'(1) << ord) - (HCC_COORD_W+1)'(1);
    return m[HCC_COORD_W-1:0];
  endfunction

  // Index to point: bit pairs low to high, HCC_HALF levels from base upward.
  function automatic stage_t pt_steps(input stage_t st, input logic [HCC_ORDER_W-1:0] ord,
                                      input logic [3:0] base,
                                      input logic [2*HCC_HALF-1:0] pairs);
    stage_t                 r;
    logic [3:0]             k;
    logic                   rx;
    logic                   ry;
    logic [HCC_COORD_W-1:0] mask;
    logic [HCC_COORD_W-1:0] t;
    r = st;
    for (int i = 0; i < HCC_HALF; i++) begin
      k  = base + 4'(i);
      rx = pairs[2*i+1];
      ry = pairs[2*i] ^ rx;
      if ({1'b0, k} < ord) begin
        mask = (HCC_COORD_W'(1) << k) - HCC_COORD_W'(1);
        if (!ry) begin
          if (rx) begin
            r.px = ~r.px & mask;
            r.py = ~r.py & mask;
          end
          t    = r.px;
          r.px = r.py;
          r.py = t;
        end
        r.px = r.px | (HCC_COORD_W'(rx) << k);
        r.py = r.py | (HCC_COORD_W'(ry) << k);
      end
    end
    return r;
  endfunction

  // Point to index: bit levels from top down, HCC_HALF levels from base downward.
  function automatic stage_t idx_steps(input stage_t st, input logic [HCC_ORDER_W-1:0] ord,
                                       input logic [3:0] base);
    stage_t                 r;
    logic [3:0]             b;
    logic                   rx;
    logic                   ry;
    logic [HCC_COORD_W-1:0] mask;
    logic [HCC_COORD_W-1:0] t;
    r = st;
    for (int i = 0; i < HCC_HALF; i++) begin
      b  = base - 4'(i);
      rx = r.px[b];
      ry = r.py[b];
      if ({1'b0, b} < ord) begin
        // (3*rx)^ry is the pair {rx, rx^ry}
        r.acc = r.acc | (HCC_INDEX_W'({rx, rx ^ ry}) << {b, 1'b0});
        mask  = (HCC_COORD_W'(1) << b) - HCC_COORD_W'(1);
        if (!ry) begin
          if (rx) begin
            r.px = ~r.px & mask;
            r.py = ~r.py & mask;
          end
          t    = r.px;
          r.px = r.py;
          r.py = t;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/hilbert_curve_converter_top.sv =====
// Channel  | Direction | Handshake          | Payload (low bit up)
// ---------+-----------+--------------------+------------------------------------------
// s_*      | in        | s_tvalid/s_tready  | tdata: curve_index, point_x, point_y
//          |           |                    | tuser: kind
// m_*      | out       | m_tvalid/m_tready  | tdata: result_index, result_x, result_y
// apb      | in/out    | psel/penable       | grid_order at byte address 0
//
// One item per cycle sustained while m_tready stays high; a result passes through the
// input, mid and result registers before it shows on m_tvalid.
// The sixteen curve levels split into two halves of eight, one per stage.
// rst is synchronous, active high, clears the stage valid bits and loads grid_order
// with 13. A stall on m_tready backs up stage by stage; s_tready drops only when all
// three registers are full and the output is stalled. No bubbles are inserted.
module hilbert_curve_converter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // curve_index [31:0], point_x [47:32], point_y [63:48]
  input  logic [hcc_pkg::HCC_DATA_W-1:0]      s_tdata,
  // kind [0]
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // result_index [31:0], result_x [47:32], result_y [63:48]
  output logic [hcc_pkg::HCC_DATA_W-1:0]      m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hcc_pkg::HCC_APB_AW-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import hcc_pkg::*;

  logic [HCC_ORDER_W-1:0] grid_order;
  logic [HCC_ORDER_W-1:0] ord;

  // Input register
  logic                   in_valid;
  logic                   in_kind;
  logic [HCC_INDEX_W-1:0] in_index;
  logic [HCC_COORD_W-1:0] in_x;
  logic [HCC_COORD_W-1:0] in_y;

  // Mid register
  logic   mid_valid;
  stage_t mid;
  stage_t mid_next;
  stage_t first;

  // Result register
  logic                  out_valid;
  logic [HCC_DATA_W-1:0] out_data;
  logic [HCC_DATA_W-1:0] out_next;
  stage_t                last;

  logic mid_ready;
  logic out_ready;

  // Configuration port: writes land on the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_order <= HCC_ORDER_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == HCC_REG_ORDER)) begin
      grid_order <= pwdata[HCC_ORDER_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      HCC_REG_ORDER: prdata = {{(32-HCC_ORDER_W){1'b0}}, grid_order};
      default:       prdata = '0;
    endcase
  end

  // Orders above the maximum saturate.
  assign ord = eff_order(grid_order);

  // Each stage advances when empty or when the next one takes its item.
  assign out_ready = !out_valid || m_tready;
  assign mid_ready = !mid_valid || out_ready;
  assign s_tready  = !in_valid  || mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind  <= s_tuser;
      in_index <= s_tdata[HCC_INDEX_W-1:0];
      in_x     <= s_tdata[HCC_INDEX_W +: HCC_COORD_W];
      in_y     <= s_tdata[HCC_INDEX_W+HCC_COORD_W +: HCC_COORD_W];
    end
  end

  // First half: low eight levels to point, or top eight levels to index.
  always_comb begin
    first = '0;
    first.kind = in_kind;
    case (in_kind)
      HCC_KIND_TO_POINT: begin
        first.acc = in_index;
        mid_next  = pt_steps(first, ord, 4'd0, in_index[2*HCC_HALF-1:0]);
      end
      HCC_KIND_TO_INDEX: begin
        first.px = in_x & coord_mask(ord);
        first.py = in_y & coord_mask(ord);
        mid_next = idx_steps(first, ord, 4'(HCC_MAX_ORDER - 1));
      end
      default: mid_next = first;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_ready) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && in_valid) begin
      mid <= mid_next;
    end
  end

  // Second half and result packing; the unused side of the result is zero.
  always_comb begin
    case (mid.kind)
      HCC_KIND_TO_POINT: begin
        last     = pt_steps(mid, ord, 4'(HCC_HALF), mid.acc[HCC_INDEX_W-1:2*HCC_HALF]);
        out_next = {last.py, last.px, {HCC_INDEX_W{1'b0}}};
      end
      HCC_KIND_TO_INDEX: begin
        last     = idx_steps(mid, ord, 4'(HCC_HALF - 1));
        out_next = {{(2*HCC_COORD_W){1'b0}}, last.acc};
      end
      default: begin
        last     = mid;
        out_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && mid_valid) begin
      out_data <= out_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== rtl/hcc_checker.sv =====
`include "hilbert_curve_converter_top_macros.svh"

module hcc_port_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [hcc_pkg::HCC_DATA_W-1:0] m_tdata
);
  import hcc_pkg::*;

  logic idx_zero;
  logic pt_zero;

  assign idx_zero = (m_tdata[HCC_INDEX_W-1:0] == '0);
  assign pt_zero  = (m_tdata[HCC_DATA_W-1:HCC_INDEX_W] == '0);

  // Output is empty right after reset.
  `HCC_ASSERT_RST(a_rst_empty, rst, !m_tvalid, "result valid right after reset")

  // Input backs off only when the whole pipeline is full and the output stalls.
  `HCC_ASSERT_NOW(a_no_bubble, !s_tready, m_tvalid && !m_tready, "input stalled without cause")

  // One direction per item: index or point side of a result is zero.
  `HCC_ASSERT_NOW(a_one_side, m_tvalid, idx_zero || pt_zero, "result carries both index and point")

  // A stalled result holds.
  `HCC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                   "stalled result changed")

endmodule

bind hilbert_curve_converter_top hcc_port_checker u_hcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/hcc_checker.sv =====
module hcc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // curve_index [31:0], point_x [47:32], point_y [63:48]
  input  logic [hcc_pkg::HCC_DATA_W-1:0]  s_tdata,
  // kind [0]
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // result_index [31:0], result_x [47:32], result_y [63:48]
  input  logic [hcc_pkg::HCC_DATA_W-1:0]  m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hcc_pkg::HCC_APB_AW-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  input  logic [31:0]                     prdata,
  input  logic                            pready,
  output int unsigned                     fail_count,
  output int unsigned                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import hcc_pkg::*;

  typedef struct packed {
    logic [HCC_COORD_W-1:0] y;
    logic [HCC_COORD_W-1:0] x;
    logic [HCC_INDEX_W-1:0] index;
  } conv_result_t;

  logic [HCC_ORDER_W-1:0] grid_order_q;
  conv_result_t           pending_results[$];
  int unsigned            mismatches;

  // Rotate or reflect a quadrant of side s.
  function automatic void quadrant_turn(input logic [63:0] s, inout logic [63:0] x,
                                        inout logic [63:0] y, input logic rx, input logic ry);
    logic [63:0] t;
    if (!ry) begin
      if (rx) begin
        x = (s - 64'd1 - (x & (s - 64'd1))) & (s - 64'd1);
        y = (s - 64'd1 - (y & (s - 64'd1))) & (s - 64'd1);
      end
      t = x;
      x = y;
      y = t;
    end
  endfunction

  function automatic conv_result_t convert_item(input logic [HCC_ORDER_W-1:0] ord_in,
                                                input logic kind,
                                                input logic [HCC_INDEX_W-1:0] idx,
                                                input logic [HCC_COORD_W-1:0] px,
                                                input logic [HCC_COORD_W-1:0] py);
    conv_result_t r;
    int unsigned  ord;
    logic [63:0]  x;
    logic [63:0]  y;
    logic [63:0]  t;
    logic [63:0]  s;
    logic [63:0]  curve_dist;
    logic [63:0]  mask;
    logic         rx;
    logic         ry;
    ord        = (ord_in > HCC_MAX_ORDER) ? HCC_MAX_ORDER : ord_in;
    r          = '0;
    curve_dist = '0;
    if (kind == HCC_KIND_TO_POINT) begin
      x = '0;
      y = '0;
      t = 64'(idx);
      for (int k = 0; k < ord; k++) begin
        s  = 64'd1 << k;
        rx = t[1];
        ry = t[0] ^ rx;
        quadrant_turn(s, x, y, rx, ry);
        if (rx) x = x + s;
        if (ry) y = y + s;
        t = t >> 2;
      end
      r.x = x[HCC_COORD_W-1:0];
      r.y = y[HCC_COORD_W-1:0];
    end else if (ord != 0) begin
      mask = (64'd1 << ord) - 64'd1;
      x    = 64'(px) & mask;
      y    = 64'(py) & mask;
      for (int k = ord; k > 0; k--) begin
        s          = 64'd1 << (k - 1);
        rx         = (x & s) != 0;
        ry         = (y & s) != 0;
        // (3*rx)^ry as a two-bit quadrant number
        curve_dist = curve_dist + s * s * 64'({rx, rx ^ ry});
        quadrant_turn(s, x, y, rx, ry);
      end
      r.index = curve_dist[HCC_INDEX_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    conv_result_t want;
    conv_result_t got;
    if (rst) begin
      grid_order_q = HCC_ORDER_RESET;
      pending_results.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == HCC_REG_ORDER) begin
        if (pwrite) grid_order_q = pwdata[HCC_ORDER_W-1:0];
        else check_field("grid_order", 32'(grid_order_q), prdata);
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(convert_item(grid_order_q, s_tuser,
                                               s_tdata[31:0], s_tdata[47:32],
                                               s_tdata[63:48]));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_results.size() == 0) begin
          $error("result with no item waiting: index %0d x %0d y %0d",
                 got.index, got.x, got.y);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_index", want.index, got.index);
          check_field("result_x", 32'(want.x), 32'(got.x));
          check_field("result_y", 32'(want.y), 32'(got.y));
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // receiver hold-off long enough to back the pipeline up into s_tready
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam logic [HCC_APB_AW-1:0] ORDER_ADDR = {HCC_REG_ORDER, 2'b00};

  // Grid orders per random phase: the extremes, zero, a saturating value and a few
  // in between. One phase draws a random order instead of its entry here.
  localparam logic [HCC_ORDER_W-1:0] PHASE_ORDERS [PHASES] =
    '{5'd1, 5'd31, 5'd0, 5'd2, 5'd16, 5'd7, 5'd20, 5'd0, 5'd3, 5'd13};

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // curve_index [31:0], point_x [47:32], point_y [63:48]
  logic [HCC_DATA_W-1:0] s_tdata  = '0;
  // kind [0]
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // result_index [31:0], result_x [47:32], result_y [63:48]
  logic [HCC_DATA_W-1:0] m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [HCC_APB_AW-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count    = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_count     = 0;
  logic        long_hold_req  = 1'b0;

  always #10 clk = ~clk;

  hilbert_curve_converter_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  hcc_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hilbert_curve_converter_top: mismatch");
      $finish;
    end
  end

  // Result side. Once requested, hold m_tready low until hold_count reaches LONG_HOLD
  // (only once per run, the count never rewinds); otherwise stall at the phase rate.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold_req && hold_count < LONG_HOLD) begin
      m_tready   <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item, with random gaps ahead of it at the phase rate, and return at the
  // edge that accepts it. Leave s_tvalid high so back-to-back items need no extra NBA.
  task automatic send_conversion(input logic kind, input logic [HCC_INDEX_W-1:0] idx,
                                 input logic [HCC_COORD_W-1:0] px,
                                 input logic [HCC_COORD_W-1:0] py);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {py, px, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  // One APB transfer to the grid_order register: setup, then access until pready.
  task automatic apb_order_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ORDER_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait for every expected result, then let the three pipeline stages settle.
  // The first edge makes sure the checker has counted the last accepted item.
  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random coordinate for the unused side of an item.
  function automatic logic [HCC_COORD_W-1:0] rand_coord();
    return HCC_COORD_W'($urandom);
  endfunction

  // Pick a curve index: corners of the grid, one past it, in-grid and raw values.
  function automatic logic [HCC_INDEX_W-1:0] pick_index(input logic [HCC_ORDER_W-1:0] ord);
    int unsigned e;
    logic [63:0] span;
    e    = (ord > HCC_MAX_ORDER) ? HCC_MAX_ORDER : ord;
    span = (64'd1 << (2 * e)) - 64'd1;
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return span[HCC_INDEX_W-1:0];
      3:       return HCC_INDEX_W'(span + 64'd1);
      4, 5:    return $urandom & span[HCC_INDEX_W-1:0];
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [HCC_COORD_W-1:0] pick_coord(input logic [HCC_ORDER_W-1:0] ord);
    int unsigned e;
    logic [31:0] span;
    e    = (ord > HCC_MAX_ORDER) ? HCC_MAX_ORDER : ord;
    span = (32'd1 << e) - 32'd1;
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return span[HCC_COORD_W-1:0];
      3:       return HCC_COORD_W'(span + 32'd1);
      4, 5:    return HCC_COORD_W'($urandom) & span[HCC_COORD_W-1:0];
      default: return HCC_COORD_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [HCC_ORDER_W-1:0] order_val;
    logic                   kind;

    // Hold reset, then release it.
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Read back the reset order, then convert the grid corners at order 13,
    // including indexes and points with bits above the grid.
    apb_order_access(1'b0, $urandom);
    send_conversion(HCC_KIND_TO_POINT, 32'h0000_0000, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_POINT, 32'h03FF_FFFF, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_POINT, 32'h0400_0000, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_POINT, 32'hFFFF_FFFF, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'h0000, 16'h0000);
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'h1FFF, 16'h1FFF);
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'h1FFF, 16'h0000);
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'hE000, 16'hE000);
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'hFFFF, 16'hFFFF);
    s_tvalid <= 1'b0;
    wait_idle();

    // Full-width grid: every index and coordinate bit is live.
    apb_order_access(1'b1, {27'($urandom), 5'd16});
    send_conversion(HCC_KIND_TO_POINT, 32'h0000_0000, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_POINT, 32'h0000_0001, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_POINT, 32'h0000_0002, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_POINT, 32'h0000_0003, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_POINT, 32'hFFFF_FFFF, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_POINT, 32'h5555_5555, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_POINT, 32'hAAAA_AAAA, rand_coord(), rand_coord());
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'hFFFF, 16'h0000);
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'h0000, 16'hFFFF);
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'hFFFF, 16'hFFFF);
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'h8000, 16'h8000);
    send_conversion(HCC_KIND_TO_INDEX, $urandom, 16'h5555, 16'hAAAA);
    s_tvalid <= 1'b0;

    // Random phases: new order each time, idling pattern rotating through
    // none, sender gaps, receiver stalls, and both lightly.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      order_val = (p == 7) ? HCC_ORDER_W'($urandom_range(31)) : PHASE_ORDERS[p];
      case (p % 4)
        0:       begin send_gap_pct <= 0;  recv_stall_pct <= 0;  end
        1:       begin send_gap_pct <= 50; recv_stall_pct <= 0;  end
        2:       begin send_gap_pct <= 0;  recv_stall_pct <= 50; end
        default: begin send_gap_pct <= 12; recv_stall_pct <= 12; end
      endcase
      apb_order_access(1'b1, {27'($urandom), order_val});
      apb_order_access(1'b0, $urandom);
      // Back-pressure: keep offering items while the receiver holds off.
      if (p == PRESSURE_PHASE) long_hold_req <= 1'b1;
      repeat (PHASE_ITEMS) begin
        kind = 1'($urandom_range(1));
        send_conversion(kind, pick_index(order_val), pick_coord(order_val),
                        pick_coord(order_val));
      end
      s_tvalid <= 1'b0;
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("hilbert_curve_converter_top: match");
    end else begin
      $display("hilbert_curve_converter_top: mismatch");
    end
    $finish;
  end

endmodule
